[rtl/core/idl_pkg.sv]
// ----------------------------------------------------------------------------
// idl_pkg
// Shared types and constants of the indexed deque list: request codes,
// controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package idl_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int OP_W      = 3;
    localparam int POS_W     = 8;
    localparam int DATA_W    = 32;
    localparam int CNT_OUT_W = 9;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ_AT    = 3'd4,
        OP_REMOVE_AT  = 3'd5,
        OP_INSERT_AT  = 3'd6
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_HEAD_DEC,
        S_PUT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FETCH,
        S_GRAB,
        S_CLOSE_RD,
        S_CLOSE_WR,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_LAST,
        IDX_POS,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_sel;

    typedef struct packed {
        logic     latch;
        logic     rd_en;
        logic     rd_next;
        logic     wr_en;
        logic     wr_next;
        logic     wr_src_word;
        t_idx_sel idx_sel;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     head_inc;
        logic     head_dec;
        logic     set_over;
        logic     capture;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            pos_lt_cnt;
        logic            pos_zero;
        logic            idx_is_pos;
        logic            idx_is_last;
        logic            idx_next_last;
        logic            out_free;
    } t_dp_sts;

endpackage

[rtl/core/idl_if.sv]
// ----------------------------------------------------------------------------
// idl_req_if / idl_rsp_if
// Valid/ready channels for list requests and their results.
// ----------------------------------------------------------------------------
interface idl_req_if;
    logic                        valid;
    logic                        ready;
    logic [idl_pkg::OP_W-1:0]    op;
    logic [idl_pkg::POS_W-1:0]   position;
    logic [idl_pkg::DATA_W-1:0]  data_in;

    modport source (output valid, output op, output position, output data_in, input ready);
    modport sink   (input valid, input op, input position, input data_in, output ready);
endinterface

interface idl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [idl_pkg::DATA_W-1:0]    data_out;
    logic                          found;
    logic                          overflow;
    logic [idl_pkg::CNT_OUT_W-1:0] entry_count;

    modport source (output valid, output data_out, output found, output overflow,
                    output entry_count, input ready);
    modport sink   (input valid, input data_out, input found, input overflow,
                    input entry_count, output ready);
endinterface

[rtl/core/idl_ram.sv]
// ----------------------------------------------------------------------------
// idl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module idl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/idl_dp.sv]
// ----------------------------------------------------------------------------
// idl_dp
// Datapath: circular entry store with head pointer and count, the
// working index for shifts, the request latch and the result register.
// ----------------------------------------------------------------------------
module idl_dp #(
    parameter int CAPACITY   = idl_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = idl_pkg::WORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  idl_pkg::t_dp_cmd                i_cmd,
    output idl_pkg::t_dp_sts                o_sts,
    input  logic [idl_pkg::OP_W-1:0]        i_op,
    input  logic [idl_pkg::POS_W-1:0]       i_position,
    input  logic [idl_pkg::DATA_W-1:0]      i_data_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [idl_pkg::DATA_W-1:0]      o_data_out,
    output logic                            o_found,
    output logic                            o_overflow,
    output logic [idl_pkg::CNT_OUT_W-1:0]   o_entry_count
);

    import idl_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW:0]   CAP_W  = (CW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [AW-1:0] HEAD_MAX = AW'(CAPACITY - 1);

    // logical position -> RAM address
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] lpos);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(lpos);
        if (sum >= CAP_W) begin
            sum = sum - CAP_W;
        end
        return sum[AW-1:0];
    endfunction

    t_op                  r_op;
    logic [POS_W-1:0]     r_pos;
    logic [WORD_WIDTH-1:0] r_word;
    logic [AW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic [WORD_WIDTH-1:0] r_value;
    logic                 r_found;
    logic                 r_over;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_data;
    logic                 r_out_found;
    logic                 r_out_over;
    logic [CNT_OUT_W-1:0] r_out_count;

    logic [CW-1:0]         idx_plus1;
    logic [CW-1:0]         count_last;
    logic [CMPW-1:0]       pos_ext;
    logic [WORD_WIDTH-1:0] ram_rdata;
    logic [WORD_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    logic                  out_free;

    assign idx_plus1  = r_idx + 1'b1;
    assign count_last = r_count - 1'b1;
    assign pos_ext    = CMPW'(r_pos);
    assign out_free   = !r_out_valid || i_out_ready;

    assign ram_raddr = f_phys(r_head, i_cmd.rd_next ? idx_plus1 : r_idx);
    assign ram_waddr = f_phys(r_head, i_cmd.wr_next ? idx_plus1 : r_idx);
    assign ram_wdata = i_cmd.wr_src_word ? r_word : ram_rdata;

    idl_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    always_comb begin
        o_sts.op            = r_op;
        o_sts.full          = (r_count == CAP_C);
        o_sts.empty         = (r_count == '0);
        o_sts.pos_lt_cnt    = (pos_ext < CMPW'(r_count));
        o_sts.pos_zero      = (r_pos == '0);
        o_sts.idx_is_pos    = (CMPW'(r_idx) == pos_ext);
        o_sts.idx_is_last   = (r_idx == count_last);
        o_sts.idx_next_last = (idx_plus1 == count_last);
        o_sts.out_free      = out_free;
    end

    always_comb begin
        unique case (i_cmd.idx_sel)
            IDX_HOLD:  n_idx = r_idx;
            IDX_COUNT: n_idx = r_count;
            IDX_LAST:  n_idx = count_last;
            IDX_POS:   n_idx = pos_ext[CW-1:0];
            IDX_ZERO:  n_idx = '0;
            IDX_INC:   n_idx = idx_plus1;
            IDX_DEC:   n_idx = r_idx - 1'b1;
            default:   n_idx = r_idx;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            n_count = count_last;
        end
    end

    always_comb begin
        n_head = r_head;
        if (i_cmd.head_inc) begin
            n_head = (r_head == HEAD_MAX) ? '0 : r_head + 1'b1;
        end else if (i_cmd.head_dec) begin
            n_head = (r_head == '0) ? HEAD_MAX : r_head - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.latch) begin
            r_op    <= t_op'(i_op);
            r_pos   <= i_position;
            r_word  <= WORD_WIDTH'(i_data_in);
            r_found <= 1'b0;
            r_over  <= 1'b0;
        end
        if (i_cmd.set_over) begin
            r_over <= 1'b1;
        end
        if (i_cmd.capture) begin
            r_value <= ram_rdata;
            r_found <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_data  <= r_found ? DATA_W'(r_value) : '0;
            r_out_found <= r_found;
            r_out_over  <= r_over;
            r_out_count <= CNT_OUT_W'(r_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_out    = r_out_data;
    assign o_found       = r_out_found;
    assign o_overflow    = r_out_over;
    assign o_entry_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_inc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |-> (r_count != CAP_C))
        else $error("count increment on full list");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result register overwritten before taken");

endmodule

[rtl/core/idl_ctrl.sv]
// ----------------------------------------------------------------------------
// idl_ctrl
// Controller: decodes each request and sequences RAM reads, writes and
// entry shifts in the datapath.
// ----------------------------------------------------------------------------
module idl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  idl_pkg::t_dp_sts  i_sts,
    output idl_pkg::t_dp_cmd  o_cmd
);

    import idl_pkg::*;

    t_state r_state, n_state;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (i_sts.op)
                    OP_PUSH_BACK: begin
                        if (i_sts.full) begin
                            cmd.set_over = 1'b1;
                        end else begin
                            cmd.idx_sel = IDX_COUNT;
                            n_state     = S_PUT;
                        end
                    end
                    OP_PUSH_FRONT: begin
                        if (i_sts.full) begin
                            cmd.set_over = 1'b1;
                        end else begin
                            n_state = S_HEAD_DEC;
                        end
                    end
                    OP_POP_BACK: begin
                        if (!i_sts.empty) begin
                            cmd.idx_sel = IDX_LAST;
                            n_state     = S_FETCH;
                        end
                    end
                    OP_POP_FRONT: begin
                        if (!i_sts.empty) begin
                            cmd.idx_sel = IDX_ZERO;
                            n_state     = S_FETCH;
                        end
                    end
                    OP_READ_AT, OP_REMOVE_AT: begin
                        if (i_sts.pos_lt_cnt) begin
                            cmd.idx_sel = IDX_POS;
                            n_state     = S_FETCH;
                        end
                    end
                    OP_INSERT_AT: begin
                        if (i_sts.full) begin
                            cmd.set_over = 1'b1;
                        end else if (!i_sts.pos_lt_cnt) begin
                            cmd.idx_sel = IDX_COUNT;
                            n_state     = S_PUT;
                        end else if (i_sts.pos_zero) begin
                            n_state = S_HEAD_DEC;
                        end else begin
                            cmd.idx_sel = IDX_LAST;
                            n_state     = S_SHIFT_RD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_HEAD_DEC: begin
                cmd.head_dec = 1'b1;
                cmd.idx_sel  = IDX_ZERO;
                n_state      = S_PUT;
            end
            S_PUT: begin
                cmd.wr_en       = 1'b1;
                cmd.wr_src_word = 1'b1;
                cmd.cnt_inc     = 1'b1;
                n_state         = S_DONE;
            end
            S_SHIFT_RD: begin
                cmd.rd_en = 1'b1;
                n_state   = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_next = 1'b1;
                if (i_sts.idx_is_pos) begin
                    n_state = S_PUT;
                end else begin
                    cmd.idx_sel = IDX_DEC;
                    n_state     = S_SHIFT_RD;
                end
            end
            S_FETCH: begin
                cmd.rd_en = 1'b1;
                n_state   = S_GRAB;
            end
            S_GRAB: begin
                cmd.capture = 1'b1;
                n_state     = S_DONE;
                priority if (i_sts.op == OP_POP_BACK) begin
                    cmd.cnt_dec = 1'b1;
                end else if (i_sts.op == OP_POP_FRONT) begin
                    cmd.cnt_dec  = 1'b1;
                    cmd.head_inc = 1'b1;
                end else if (i_sts.op == OP_REMOVE_AT) begin
                    if (i_sts.idx_is_last) begin
                        cmd.cnt_dec = 1'b1;
                    end else begin
                        n_state = S_CLOSE_RD;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CLOSE_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_next = 1'b1;
                n_state     = S_CLOSE_WR;
            end
            S_CLOSE_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.idx_sel = IDX_INC;
                if (i_sts.idx_next_last) begin
                    cmd.cnt_dec = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    n_state = S_CLOSE_RD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

    a_accept_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");

    a_one_ram_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.rd_en, cmd.wr_en, cmd.out_load}))
        else $error("overlapping RAM access or result load");

endmodule

[rtl/core/indexed_deque_list.sv]
// ----------------------------------------------------------------------------
// indexed_deque_list
// Ordered list of up to CAPACITY words with push/pop at both ends and
// read, remove and insert at a position. Entries sit in a circular RAM
// addressed from a head pointer; one request is handled at a time.
// A request that changes nothing (dropped push or insert on a full list,
// pop from an empty list, read or remove out of range, unused code) goes
// from decode to the result; push back and an insert that appends write
// the word at the end; push front and an insert at position 0 first step
// the head back; pop, read and a remove of the last entry read the RAM
// and capture the word. An insert in the middle moves each entry from the
// last down to the position up by one (count - position entries); any
// other remove moves each entry after the position down by one (count - 1
// - position entries); each move is one RAM read, then one RAM write.
// The next request is taken as soon as the result sits in the output
// register, before it is collected; a result not yet collected holds the
// following one back until the output register frees.
// ----------------------------------------------------------------------------
module indexed_deque_list #(
    parameter int CAPACITY   = idl_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = idl_pkg::WORD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    idl_req_if.sink    i_req,
    idl_rsp_if.source  o_rsp
);

    import idl_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_req.ready = in_ready;

    idl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    idl_dp #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_req.op),
        .i_position    (i_req.position),
        .i_data_in     (i_req.data_in),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_data_out    (o_rsp.data_out),
        .o_found       (o_rsp.found),
        .o_overflow    (o_rsp.overflow),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for indexed_deque_list. Requests go in over the request
// channel while a queue-based model of the list predicts each result. Results
// are checked field by field in order. Directed corner cases come first,
// then a fill to capacity and back, then random mixes under three idling
// profiles.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import idl_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic [DATA_W-1:0]    data_out;
        logic                 found;
        logic                 overflow;
        logic [CNT_OUT_W-1:0] entry_count;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    idl_req_if req_if ();
    idl_rsp_if rsp_if ();

    indexed_deque_list u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic [DATA_W-1:0] list_words[$];
    t_list_result      result_q[$];
    t_list_result      oldest;
    int unsigned       req_idle_pct;
    int unsigned       rsp_idle_pct;
    int unsigned       fail_count;
    int unsigned       cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_list_result apply_list_op(input logic [OP_W-1:0]   op,
                                                   input logic [POS_W-1:0]  pos,
                                                   input logic [DATA_W-1:0] word);
        t_list_result r;
        int unsigned  p;
        r = '0;
        p = pos;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_AT: begin
                if (list_words.size() >= CAPACITY_DEF) begin
                    r.overflow = 1'b1;
                end else if (op == OP_PUSH_FRONT) begin
                    list_words.push_front(word);
                end else if (op == OP_PUSH_BACK || p >= list_words.size()) begin
                    list_words.push_back(word);
                end else begin
                    list_words.insert(p, word);
                end
            end
            OP_POP_BACK: begin
                if (list_words.size() > 0) begin
                    r.found    = 1'b1;
                    r.data_out = list_words.pop_back();
                end
            end
            OP_POP_FRONT: begin
                if (list_words.size() > 0) begin
                    r.found    = 1'b1;
                    r.data_out = list_words.pop_front();
                end
            end
            OP_READ_AT: begin
                if (p < list_words.size()) begin
                    r.found    = 1'b1;
                    r.data_out = list_words[p];
                end
            end
            OP_REMOVE_AT: begin
                if (p < list_words.size()) begin
                    r.found    = 1'b1;
                    r.data_out = list_words[p];
                    list_words.delete(p);
                end
            end
            default: ;
        endcase
        r.entry_count = CNT_OUT_W'(list_words.size());
        return r;
    endfunction

    task automatic send_request(input logic [OP_W-1:0]   op,
                                input logic [POS_W-1:0]  pos,
                                input logic [DATA_W-1:0] word);
        while ($urandom_range(99) < req_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.op       <= op;
        req_if.position <= pos;
        req_if.data_in  <= word;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        result_q.push_back(apply_list_op(op, pos, word));
    endtask

    task automatic pause_until_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (result_q.size() == 0) begin
                $error("result with no request outstanding: data_out %h", rsp_if.data_out);
                fail_count++;
            end else begin
                oldest = result_q.pop_front();
                if (rsp_if.data_out !== oldest.data_out) begin
                    $error("data_out: expected %h, got %h", oldest.data_out, rsp_if.data_out);
                    fail_count++;
                end
                if (rsp_if.found !== oldest.found) begin
                    $error("found: expected %b, got %b", oldest.found, rsp_if.found);
                    fail_count++;
                end
                if (rsp_if.overflow !== oldest.overflow) begin
                    $error("overflow: expected %b, got %b", oldest.overflow, rsp_if.overflow);
                    fail_count++;
                end
                if (rsp_if.entry_count !== oldest.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           oldest.entry_count, rsp_if.entry_count);
                    fail_count++;
                end
            end
        end
        rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // empty list, out of range positions, inserts at both ends and in the middle
    task automatic test_edge_cases();
        send_request(OP_POP_BACK,   8'd0,   32'h0000_0000);
        send_request(OP_POP_FRONT,  8'd0,   32'h0000_0000);
        send_request(OP_READ_AT,    8'd0,   32'h0000_0000);
        send_request(OP_REMOVE_AT,  8'd0,   32'h0000_0000);
        send_request(OP_UNUSED,     8'hFF,  32'hFFFF_FFFF);
        send_request(OP_INSERT_AT,  8'd5,   32'hA5A5_5A5A);
        send_request(OP_PUSH_BACK,  8'hFF,  32'hFFFF_FFFF);
        send_request(OP_PUSH_FRONT, 8'h00,  32'h0000_0000);
        send_request(OP_INSERT_AT,  8'd0,   32'h1234_5678);
        send_request(OP_INSERT_AT,  8'd2,   32'h8000_0001);
        send_request(OP_INSERT_AT,  8'hFF,  32'h0F0F_F0F0);
        send_request(OP_READ_AT,    8'd0,   32'h0000_0000);
        send_request(OP_READ_AT,    8'd5,   32'h0000_0000);
        send_request(OP_READ_AT,    8'd6,   32'h0000_0000);
        send_request(OP_READ_AT,    8'hFF,  32'h0000_0000);
        send_request(OP_REMOVE_AT,  8'd2,   32'h0000_0000);
        send_request(OP_REMOVE_AT,  8'd5,   32'h0000_0000);
        send_request(OP_REMOVE_AT,  8'd4,   32'h0000_0000);
        send_request(OP_REMOVE_AT,  8'd0,   32'h0000_0000);
        send_request(OP_POP_BACK,   8'd0,   32'h0000_0000);
        send_request(OP_POP_FRONT,  8'd0,   32'h0000_0000);
        send_request(OP_POP_BACK,   8'd0,   32'h0000_0000);
        send_request(OP_POP_FRONT,  8'd0,   32'h0000_0000);
        pause_until_drained();
    endtask

    // fill to capacity, poke the full list, then empty it again
    task automatic test_full_list();
        int unsigned held;
        while (list_words.size() < CAPACITY_DEF) begin
            held = list_words.size();
            case ($urandom_range(3))
                0:       send_request(OP_PUSH_FRONT, POS_W'($urandom), $urandom);
                1:       send_request(OP_INSERT_AT, POS_W'($urandom_range(held)), $urandom);
                default: send_request(OP_PUSH_BACK, POS_W'($urandom), $urandom);
            endcase
        end
        send_request(OP_PUSH_BACK,  8'd0,   $urandom);
        send_request(OP_PUSH_FRONT, 8'd0,   $urandom);
        send_request(OP_INSERT_AT,  8'd0,   $urandom);
        send_request(OP_INSERT_AT,  POS_W'($urandom_range(1, 254)), $urandom);
        send_request(OP_INSERT_AT,  8'hFF,  $urandom);
        send_request(OP_READ_AT,    8'd0,   $urandom);
        send_request(OP_READ_AT,    8'hFF,  $urandom);
        send_request(OP_REMOVE_AT,  8'hFF,  $urandom);
        send_request(OP_INSERT_AT,  8'hFF,  $urandom);
        send_request(OP_REMOVE_AT,  8'd0,   $urandom);
        send_request(OP_INSERT_AT,  8'd0,   $urandom);
        send_request(OP_REMOVE_AT,  POS_W'($urandom_range(1, 254)), $urandom);
        send_request(OP_PUSH_BACK,  8'd0,   $urandom);
        send_request(OP_UNUSED,     8'd0,   $urandom);
        pause_until_drained();
        while (list_words.size() > 0) begin
            held = list_words.size();
            case ($urandom_range(2))
                0:       send_request(OP_POP_BACK, POS_W'($urandom), $urandom);
                1:       send_request(OP_POP_FRONT, POS_W'($urandom), $urandom);
                default: send_request(OP_REMOVE_AT, POS_W'($urandom_range(held - 1)), $urandom);
            endcase
        end
        pause_until_drained();
    endtask

    // random operations steered toward a fill level that changes every burst
    task automatic test_random_mix(input int unsigned n_items);
        int unsigned       fill_goal;
        int unsigned       roll;
        int unsigned       held;
        logic              grow;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        fill_goal = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                roll = $urandom_range(99);
                if (roll < 70) fill_goal = $urandom_range(12);
                else if (roll < 95) fill_goal = $urandom_range(64);
                else fill_goal = $urandom_range(CAPACITY_DEF);
            end
            held = list_words.size();
            roll = $urandom_range(99);
            if (roll < 3) begin
                op = OP_UNUSED;
            end else if (roll < 15) begin
                op = OP_READ_AT;
            end else begin
                grow = (held < fill_goal) ^ (roll >= 85);
                case ($urandom_range(2))
                    0:       op = grow ? OP_PUSH_BACK  : OP_POP_BACK;
                    1:       op = grow ? OP_PUSH_FRONT : OP_POP_FRONT;
                    default: op = grow ? OP_INSERT_AT  : OP_REMOVE_AT;
                endcase
            end
            if ($urandom_range(9) < 8) pos = POS_W'($urandom_range(held > 255 ? 255 : held));
            else pos = POS_W'($urandom_range(255));
            if ($urandom_range(99) == 0) pause_until_drained();
            send_request(op, pos, $urandom);
        end
        pause_until_drained();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.op       = '0;
        req_if.position = '0;
        req_if.data_in  = '0;
        rsp_if.ready    = 1'b0;
        fail_count      = 0;
        cycle_count     = 0;
        req_idle_pct    = 10;
        rsp_idle_pct    = 86;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_cases();
        test_full_list();
        test_random_mix(390);

        req_idle_pct = 86;
        rsp_idle_pct = 10;
        test_random_mix(390);

        req_idle_pct = 0;
        rsp_idle_pct = 0;
        test_random_mix(390);

        pause_until_drained();
        repeat (600) @(posedge i_clk);
        if (fail_count == 0 && result_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
